### src/resp_multibulk_command_parser_macros.svh
// Assertion macros for the RESP multibulk request parser checker.
// Expects signals named clk and rst_n in the scope where a macro is used.
`ifndef RESP_MULTIBULK_COMMAND_PARSER_MACROS_SVH
`define RESP_MULTIBULK_COMMAND_PARSER_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define RMBP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rmbp: implication violated");

// A stalled beat keeps its valid and the given signal on the next cycle.
`define RMBP_ASSERT_HOLD(label, vld, rdy, sig) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        ((vld) && !(rdy)) |=> ((vld) && $stable(sig))) \
        else $error("rmbp: stalled beat changed");

`endif

### src/rmbp_pkg.sv
// Shared types and constants for the RESP multibulk request parser.
// No dependencies.
package rmbp_pkg;

    localparam int COUNT_BITS     = 31;
    localparam int ARG_NUM_BITS   = 31;
    localparam int PROD_BITS      = COUNT_BITS + 4;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    typedef enum logic [2:0] {
        CLS_STAR,
        CLS_DOLLAR,
        CLS_CR,
        CLS_LF,
        CLS_DIGIT,
        CLS_MINUS,
        CLS_OTHER
    } byte_class_t;

    typedef struct packed {
        byte_class_t cls;
        logic [3:0]  digit;
        logic [7:0]  raw;
    } token_t;

    typedef enum logic [2:0] {
        PH_STAR,
        PH_COUNT,
        PH_DOLLAR,
        PH_LEN,
        PH_PAYLOAD,
        PH_TERM
    } phase_t;

    typedef enum logic [1:0] {
        K_BYTE,
        K_END,
        K_EMPTY,
        K_ERR
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE,
        ERR_NO_STAR,
        ERR_BAD_COUNT,
        ERR_NO_DOLLAR,
        ERR_BAD_LEN,
        ERR_BAD_TERM
    } err_code_t;

    typedef struct packed {
        kind_t                  kind;
        logic [7:0]             data;
        logic [COUNT_BITS-1:0]  idx;
        logic                   cend;
        err_code_t              err;
    } result_t;

endpackage

### src/rmbp_front.sv
// Input stage: accepts raw bytes and classifies them into tokens for the queue.
// Depends on rmbp_pkg.
module rmbp_front (
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        in_byte,
    input  logic              q_full,
    output logic              push,
    output rmbp_pkg::token_t  token
);
    import rmbp_pkg::*;

    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

    always_comb
    begin
        token.raw   = in_byte;
        token.digit = 4'd0;
        priority if (in_byte >= CH_ZERO && in_byte <= CH_NINE)
        begin
            token.cls   = CLS_DIGIT;
            token.digit = 4'(in_byte - CH_ZERO);
        end
        else if (in_byte == CH_STAR)
            token.cls = CLS_STAR;
        else if (in_byte == CH_DOLLAR)
            token.cls = CLS_DOLLAR;
        else if (in_byte == CH_CR)
            token.cls = CLS_CR;
        else if (in_byte == CH_LF)
            token.cls = CLS_LF;
        else if (in_byte == CH_MINUS)
            token.cls = CLS_MINUS;
        else
            token.cls = CLS_OTHER;
    end

endmodule

### src/rmbp_queue.sv
// Short token FIFO between the classifier and the parser.
// Depends on rmbp_pkg.
module rmbp_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  rmbp_pkg::token_t  push_token,
    output logic              full,
    input  logic              pop,
    output logic              q_valid,
    output rmbp_pkg::token_t  head
);
    import rmbp_pkg::*;

    token_t                mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0]  count_reg, count_next;

    assign full    = (count_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign head    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_token;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### src/rmbp_back.sv
// Parser: RESP phase machine, decimal line scanner, counters and result register.
// Depends on rmbp_pkg.
module rmbp_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  rmbp_pkg::token_t   head,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output rmbp_pkg::result_t  res
);
    import rmbp_pkg::*;

    phase_t                 phase_reg, phase_next;
    logic [COUNT_BITS-1:0]  number_acc_reg, number_acc_next;
    logic                   number_negative_reg, number_negative_next;
    logic                   any_digit_seen_reg, any_digit_seen_next;
    logic                   digits_finished_reg, digits_finished_next;
    logic                   number_overflow_reg, number_overflow_next;
    logic                   cr_pending_reg, cr_pending_next;
    logic [COUNT_BITS-1:0]  args_total_reg, args_total_next;
    logic [COUNT_BITS-1:0]  arg_counter_reg, arg_counter_next;
    logic [COUNT_BITS-1:0]  bytes_left_reg, bytes_left_next;
    logic                   terminator_pos_reg, terminator_pos_next;
    logic                   out_valid_reg, out_valid_next;
    result_t                res_reg, res_next;

    logic                   step;
    logic                   line_done;
    logic                   number_ok;
    logic                   acc_zero;
    logic                   last_arg;
    logic                   last_byte;
    logic [COUNT_BITS:0]    arg_plus_one;
    logic [PROD_BITS-1:0]   acc_wide;
    logic [PROD_BITS-1:0]   prod;
    logic                   prod_over;
    logic                   scan_en;
    logic                   res_valid;
    result_t                res_comb;

    assign pop       = q_valid && (!out_valid_reg || out_ready);
    assign step      = pop;
    assign out_valid = out_valid_reg;
    assign res       = res_reg;

    assign line_done    = cr_pending_reg && (head.cls == CLS_LF);
    assign acc_zero     = (number_acc_reg == '0);
    assign number_ok    = any_digit_seen_reg && !number_overflow_reg &&
                          !(number_negative_reg && !acc_zero);
    assign arg_plus_one = (COUNT_BITS + 1)'(arg_counter_reg) + (COUNT_BITS + 1)'(1);
    assign last_arg     = (arg_plus_one >= (COUNT_BITS + 1)'(args_total_reg));
    assign last_byte    = (bytes_left_reg == COUNT_BITS'(1));
    assign acc_wide     = PROD_BITS'(number_acc_reg);
    assign prod         = (acc_wide << 3) + (acc_wide << 1) + PROD_BITS'(head.digit);
    assign prod_over    = |prod[PROD_BITS-1:COUNT_BITS];
    assign scan_en      = step && ((phase_reg == PH_COUNT) || (phase_reg == PH_LEN));

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (step)
        begin
            unique case (phase_reg)
                PH_COUNT:
                    if (line_done)
                        phase_next = (number_ok && !acc_zero) ? PH_DOLLAR : PH_STAR;
                PH_DOLLAR:
                    phase_next = (head.cls == CLS_DOLLAR) ? PH_LEN : PH_STAR;
                PH_LEN:
                    if (line_done)
                    begin
                        if (!number_ok)
                            phase_next = PH_STAR;
                        else
                            phase_next = acc_zero ? PH_TERM : PH_PAYLOAD;
                    end
                PH_PAYLOAD:
                    if (last_byte)
                        phase_next = PH_TERM;
                PH_TERM:
                    if (!terminator_pos_reg)
                        phase_next = (head.cls == CLS_CR) ? PH_TERM : PH_STAR;
                    else if (head.cls != CLS_LF || last_arg)
                        phase_next = PH_STAR;
                    else
                        phase_next = PH_DOLLAR;
                default:
                    phase_next = (head.cls == CLS_STAR) ? PH_COUNT : PH_STAR;
            endcase
        end
    end

    // result of the current beat
    always_comb
    begin
        res_valid     = 1'b0;
        res_comb.kind = K_ERR;
        res_comb.data = 8'd0;
        res_comb.idx  = arg_counter_reg;
        res_comb.cend = 1'b0;
        res_comb.err  = ERR_NONE;
        unique case (phase_reg)
            PH_COUNT:
                if (line_done)
                begin
                    res_comb.idx = '0;
                    if (!number_ok)
                    begin
                        res_valid    = 1'b1;
                        res_comb.err = ERR_BAD_COUNT;
                    end
                    else if (acc_zero)
                    begin
                        res_valid     = 1'b1;
                        res_comb.kind = K_EMPTY;
                        res_comb.cend = 1'b1;
                    end
                end
            PH_DOLLAR:
                if (head.cls != CLS_DOLLAR)
                begin
                    res_valid    = 1'b1;
                    res_comb.err = ERR_NO_DOLLAR;
                end
            PH_LEN:
                if (line_done && !number_ok)
                begin
                    res_valid    = 1'b1;
                    res_comb.err = ERR_BAD_LEN;
                end
            PH_PAYLOAD:
            begin
                res_valid     = 1'b1;
                res_comb.kind = K_BYTE;
                res_comb.data = head.raw;
            end
            PH_TERM:
                if (!terminator_pos_reg)
                begin
                    if (head.cls != CLS_CR)
                    begin
                        res_valid    = 1'b1;
                        res_comb.err = ERR_BAD_TERM;
                    end
                end
                else if (head.cls != CLS_LF)
                begin
                    res_valid    = 1'b1;
                    res_comb.err = ERR_BAD_TERM;
                end
                else
                begin
                    res_valid     = 1'b1;
                    res_comb.kind = K_END;
                    res_comb.cend = last_arg;
                end
            default:
                if (head.cls != CLS_STAR)
                begin
                    res_valid    = 1'b1;
                    res_comb.idx = '0;
                    res_comb.err = ERR_NO_STAR;
                end
        endcase
    end

    // scanner and counters
    always_comb
    begin
        number_acc_next      = number_acc_reg;
        number_negative_next = number_negative_reg;
        any_digit_seen_next  = any_digit_seen_reg;
        digits_finished_next = digits_finished_reg;
        number_overflow_next = number_overflow_reg;
        cr_pending_next      = cr_pending_reg;
        args_total_next      = args_total_reg;
        arg_counter_next     = arg_counter_reg;
        bytes_left_next      = bytes_left_reg;
        terminator_pos_next  = terminator_pos_reg;

        // a CR not followed by LF ends the digits
        if (scan_en)
        begin
            if (line_done)
                cr_pending_next = 1'b0;
            else if (cr_pending_reg)
            begin
                digits_finished_next = 1'b1;
                cr_pending_next      = (head.cls == CLS_CR);
            end
            else if (head.cls == CLS_CR)
                cr_pending_next = 1'b1;
            else if (!digits_finished_reg)
            begin
                if (head.cls == CLS_DIGIT)
                begin
                    any_digit_seen_next = 1'b1;
                    if (!number_overflow_reg)
                    begin
                        if (prod_over)
                            number_overflow_next = 1'b1;
                        else
                            number_acc_next = prod[COUNT_BITS-1:0];
                    end
                end
                else if (head.cls == CLS_MINUS && !any_digit_seen_reg &&
                         !number_negative_reg)
                    number_negative_next = 1'b1;
                else
                    digits_finished_next = 1'b1;
            end
        end

        if (step)
        begin
            unique case (phase_reg)
                PH_COUNT:
                    if (line_done && number_ok)
                    begin
                        args_total_next  = number_acc_reg;
                        arg_counter_next = '0;
                    end
                PH_DOLLAR:
                    if (head.cls == CLS_DOLLAR)
                    begin
                        number_acc_next      = '0;
                        number_negative_next = 1'b0;
                        any_digit_seen_next  = 1'b0;
                        digits_finished_next = 1'b0;
                        number_overflow_next = 1'b0;
                        cr_pending_next      = 1'b0;
                    end
                PH_LEN:
                    if (line_done && number_ok)
                    begin
                        bytes_left_next     = number_acc_reg;
                        terminator_pos_next = 1'b0;
                    end
                PH_PAYLOAD:
                begin
                    bytes_left_next = bytes_left_reg - COUNT_BITS'(1);
                    if (last_byte)
                        terminator_pos_next = 1'b0;
                end
                PH_TERM:
                    if (!terminator_pos_reg)
                    begin
                        if (head.cls == CLS_CR)
                            terminator_pos_next = 1'b1;
                    end
                    else if (head.cls == CLS_LF)
                    begin
                        terminator_pos_next = 1'b0;
                        if (!last_arg)
                            arg_counter_next = arg_plus_one[COUNT_BITS-1:0];
                    end
                default:
                    if (head.cls == CLS_STAR)
                    begin
                        number_acc_next      = '0;
                        number_negative_next = 1'b0;
                        any_digit_seen_next  = 1'b0;
                        digits_finished_next = 1'b0;
                        number_overflow_next = 1'b0;
                        cr_pending_next      = 1'b0;
                    end
            endcase
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        res_next       = res_reg;
        if (step)
        begin
            out_valid_next = res_valid;
            if (res_valid)
                res_next = res_comb;
        end
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= PH_STAR;
            number_acc_reg      <= '0;
            number_negative_reg <= 1'b0;
            any_digit_seen_reg  <= 1'b0;
            digits_finished_reg <= 1'b0;
            number_overflow_reg <= 1'b0;
            cr_pending_reg      <= 1'b0;
            args_total_reg      <= '0;
            arg_counter_reg     <= '0;
            bytes_left_reg      <= '0;
            terminator_pos_reg  <= 1'b0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            phase_reg           <= phase_next;
            number_acc_reg      <= number_acc_next;
            number_negative_reg <= number_negative_next;
            any_digit_seen_reg  <= any_digit_seen_next;
            digits_finished_reg <= digits_finished_next;
            number_overflow_reg <= number_overflow_next;
            cr_pending_reg      <= cr_pending_next;
            args_total_reg      <= args_total_next;
            arg_counter_reg     <= arg_counter_next;
            bytes_left_reg      <= bytes_left_next;
            terminator_pos_reg  <= terminator_pos_next;
            out_valid_reg       <= out_valid_next;
        end
    end

endmodule

### src/resp_multibulk_command_parser.sv
// RESP2 multibulk request parser. Takes one request byte per cycle and
// sustains one byte per cycle while the result side keeps taking beats.
// Each byte is classified on entry, passes a 4-beat queue and is consumed
// by the parser one per cycle; a byte that yields a result is stored in the
// queue, then registered at the output when the parser consumes it. The
// parser is the pacing unit: it consumes a byte only when its output
// register is empty or being drained, so the queue absorbs short output
// stalls. No clearing pass after reset. Depends on rmbp_pkg, rmbp_front,
// rmbp_queue and rmbp_back.
module resp_multibulk_command_parser (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [7:0]   in_byte,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [1:0]   kind,
    output logic [7:0]   data_byte,
    output logic [30:0]  arg_num,
    output logic         command_end,
    output logic [2:0]   error_code
);
    import rmbp_pkg::*;

    logic     q_full;
    logic     push;
    token_t   push_token;
    logic     pop;
    logic     q_valid;
    token_t   head;
    result_t  res;

    rmbp_front u_front (
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_byte  (in_byte),
        .q_full   (q_full),
        .push     (push),
        .token    (push_token)
    );

    rmbp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_token (push_token),
        .full       (q_full),
        .pop        (pop),
        .q_valid    (q_valid),
        .head       (head)
    );

    rmbp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res       (res)
    );

    assign kind        = res.kind;
    assign data_byte   = res.data;
    assign arg_num     = ARG_NUM_BITS'(res.idx);
    assign command_end = res.cend;
    assign error_code  = res.err;

endmodule

### src/rmbp_checker.sv
// Port-level checker for the RESP multibulk request parser, bound to the top.
// Depends on rmbp_pkg and resp_multibulk_command_parser_macros.svh.
`include "resp_multibulk_command_parser_macros.svh"

module rmbp_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         out_valid,
    input  logic         out_ready,
    input  logic [1:0]   kind,
    input  logic [7:0]   data_byte,
    input  logic [30:0]  arg_num,
    input  logic         command_end,
    input  logic [2:0]   error_code
);
    import rmbp_pkg::*;

    `RMBP_ASSERT_HOLD(a_out_hold_kind, out_valid, out_ready, kind)
    `RMBP_ASSERT_IMP(a_data_only_on_byte, out_valid && kind != K_BYTE, data_byte == 8'd0)
    `RMBP_ASSERT_IMP(a_err_code_iff_err, out_valid, (kind == K_ERR) == (error_code != ERR_NONE))
    `RMBP_ASSERT_IMP(a_empty_shape, out_valid && kind == K_EMPTY, command_end && arg_num == 31'd0)
    `RMBP_ASSERT_IMP(a_cend_kinds, out_valid && command_end, kind == K_END || kind == K_EMPTY)

endmodule

bind resp_multibulk_command_parser rmbp_checker u_rmbp_checker (.*);

### bench/resp_multibulk_command_parser_test.sv
`timescale 1ns / 100ps
// Self-checking bench for resp_multibulk_command_parser: streams RESP2 request bytes,
// predicts every payload, end, empty and error beat, and compares them in order.
// Depends on rmbp_pkg and the parser RTL.
module resp_multibulk_command_parser_test;
    import rmbp_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_BYTES = 1150;
    localparam int DRAIN_CYCLES = 20;
    localparam logic [35:0] COUNT_MAX = (36'd1 << COUNT_BITS) - 36'd1;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [7:0]            in_byte = 8'h00;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [1:0]            kind;
    logic [7:0]            data_byte;
    logic [30:0]           arg_num;
    logic                  command_end;
    logic [2:0]            error_code;

    int      errors = 0;
    int      cycles = 0;
    int      bytes_sent = 0;
    bit      send_idle = 1'b1;
    bit      recv_idle = 1'b1;
    result_t expected_results[$];
    logic [7:0] frame[$];

    // parser state mirror
    phase_t                ph = PH_STAR;
    logic [COUNT_BITS-1:0] num_acc = '0;
    bit                    num_neg, seen_digit, digits_done, num_ovf, cr_wait;
    logic [COUNT_BITS-1:0] args_total = '0;
    logic [COUNT_BITS-1:0] arg_no = '0;
    logic [COUNT_BITS-1:0] bytes_left = '0;
    bit                    term_pos;

    resp_multibulk_command_parser u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_byte     (in_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .data_byte   (data_byte),
        .arg_num     (arg_num),
        .command_end (command_end),
        .error_code  (error_code)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("resp_multibulk_command_parser_test: errors");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        out_ready <= !recv_idle || ($urandom_range(99) >= 16);
    end

    // ---------------- predictor ----------------

    function automatic void clear_number();
        num_acc     = '0;
        num_neg     = 1'b0;
        seen_digit  = 1'b0;
        digits_done = 1'b0;
        num_ovf     = 1'b0;
        cr_wait     = 1'b0;
    endfunction

    function automatic void reset_parser();
        ph         = PH_STAR;
        clear_number();
        args_total = '0;
        arg_no     = '0;
        bytes_left = '0;
        term_pos   = 1'b0;
    endfunction

    function automatic void scan_content(logic [7:0] b);
        logic [35:0] grown;
        if (digits_done)
            return;
        if (b >= CH_ZERO && b <= CH_NINE)
        begin
            seen_digit = 1'b1;
            if (!num_ovf)
            begin
                grown = num_acc * 36'd10 + (b - CH_ZERO);
                if (grown > COUNT_MAX)
                    num_ovf = 1'b1;
                else
                    num_acc = grown[COUNT_BITS-1:0];
            end
        end
        else if (b == CH_MINUS && !seen_digit && !num_neg)
            num_neg = 1'b1;
        else
            digits_done = 1'b1;
    endfunction

    // true when b is the LF right after a CR
    function automatic bit line_end(logic [7:0] b);
        if (cr_wait)
        begin
            cr_wait = 1'b0;
            if (b == CH_LF)
                return 1'b1;
            scan_content(CH_CR);
        end
        if (b == CH_CR)
            cr_wait = 1'b1;
        else
            scan_content(b);
        return 1'b0;
    endfunction

    function automatic bit number_valid();
        return seen_digit && !num_ovf && !(num_neg && num_acc != '0);
    endfunction

    function automatic void note_result(kind_t k, logic [7:0] d, logic [30:0] i, logic c,
                                        err_code_t e);
        result_t r;
        r.kind = k;
        r.data = d;
        r.idx  = i;
        r.cend = c;
        r.err  = e;
        expected_results.push_back(r);
    endfunction

    function automatic void reject(err_code_t e, logic [30:0] i);
        ph = PH_STAR;
        note_result(K_ERR, 8'h00, i, 1'b0, e);
    endfunction

    function automatic void parse_byte(logic [7:0] b);
        case (ph)
            PH_COUNT:
                if (line_end(b))
                begin
                    if (!number_valid())
                        reject(ERR_BAD_COUNT, '0);
                    else
                    begin
                        args_total = num_acc;
                        arg_no     = '0;
                        if (args_total == '0)
                        begin
                            ph = PH_STAR;
                            note_result(K_EMPTY, 8'h00, '0, 1'b1, ERR_NONE);
                        end
                        else
                            ph = PH_DOLLAR;
                    end
                end
            PH_DOLLAR:
                if (b != CH_DOLLAR)
                    reject(ERR_NO_DOLLAR, arg_no);
                else
                begin
                    clear_number();
                    ph = PH_LEN;
                end
            PH_LEN:
                if (line_end(b))
                begin
                    if (!number_valid())
                        reject(ERR_BAD_LEN, arg_no);
                    else
                    begin
                        bytes_left = num_acc;
                        term_pos   = 1'b0;
                        ph = (bytes_left == '0) ? PH_TERM : PH_PAYLOAD;
                    end
                end
            PH_PAYLOAD:
            begin
                bytes_left = bytes_left - 1'b1;
                if (bytes_left == '0)
                begin
                    term_pos = 1'b0;
                    ph = PH_TERM;
                end
                note_result(K_BYTE, b, arg_no, 1'b0, ERR_NONE);
            end
            PH_TERM:
                if (!term_pos)
                begin
                    if (b != CH_CR)
                        reject(ERR_BAD_TERM, arg_no);
                    else
                        term_pos = 1'b1;
                end
                else if (b != CH_LF)
                    reject(ERR_BAD_TERM, arg_no);
                else
                begin
                    term_pos = 1'b0;
                    if ({1'b0, arg_no} + 32'd1 >= {1'b0, args_total})
                    begin
                        ph = PH_STAR;
                        note_result(K_END, 8'h00, arg_no, 1'b1, ERR_NONE);
                    end
                    else
                    begin
                        note_result(K_END, 8'h00, arg_no, 1'b0, ERR_NONE);
                        arg_no = arg_no + 1'b1;
                        ph = PH_DOLLAR;
                    end
                end
            default:
                if (b != CH_STAR)
                    reject(ERR_NO_STAR, '0);
                else
                begin
                    clear_number();
                    ph = PH_COUNT;
                end
        endcase
    endfunction

    // ---------------- checking ----------------

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        errors++;
        if (errors <= 40)
            $display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, want);
    endtask

    always @(posedge clk)
    begin : check_beat
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected beat, kind", kind, 0);
            else
            begin
                want = expected_results.pop_front();
                if (kind !== want.kind)
                    report_mismatch("kind", kind, want.kind);
                if (data_byte !== want.data)
                    report_mismatch("data_byte", data_byte, want.data);
                if (arg_num !== want.idx)
                    report_mismatch("arg_num", arg_num, want.idx);
                if (command_end !== want.cend)
                    report_mismatch("command_end", command_end, want.cend);
                if (error_code !== want.err)
                    report_mismatch("error_code", error_code, want.err);
            end
        end
    end

    // ---------------- stimulus ----------------

    task automatic send_byte(input logic [7:0] b);
        if (send_idle && $urandom_range(99) < 16)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        do @(posedge clk); while (!in_ready);
        parse_byte(b);
        bytes_sent++;
    endtask

    task automatic send_frame();
        foreach (frame[i])
            send_byte(frame[i]);
        frame.delete();
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_results.size() != 0);
    endtask

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++)
            frame.push_back(s[i]);
    endfunction

    function automatic void add_crlf();
        frame.push_back(CH_CR);
        frame.push_back(CH_LF);
    endfunction

    function automatic void add_line(string s);
        add_text(s);
        add_crlf();
    endfunction

    // valid number line with random cosmetic variants
    function automatic void add_number_line(logic [7:0] lead, int unsigned v);
        int style;
        style = $urandom_range(0, 9);
        frame.push_back(lead);
        case (style)
            0: add_text($sformatf("00%0d", v));
            1: add_text($sformatf("%0d x", v));
            2:
            begin
                add_text($sformatf("%0d", v));
                frame.push_back(CH_CR);
                add_text("7");
            end
            3: add_text(v == 0 ? "-0" : $sformatf("%0d", v));
            default: add_text($sformatf("%0d", v));
        endcase
        add_crlf();
    endfunction

    function automatic void add_bad_number_line(logic [7:0] lead);
        frame.push_back(lead);
        case ($urandom_range(0, 4))
            0: add_line("");
            1: add_line($sformatf("-%0d", $urandom_range(1, 9)));
            2: add_line("4294967296");
            3: add_line("x12");
            default: add_line("-");
        endcase
    endfunction

    function automatic void add_command(int unsigned nargs, int unsigned maxlen);
        int unsigned len;
        add_number_line(CH_STAR, nargs);
        for (int unsigned a = 0; a < nargs; a++)
        begin
            len = ($urandom_range(19) == 0) ? $urandom_range(0, 40) : $urandom_range(0, maxlen);
            add_number_line(CH_DOLLAR, len);
            repeat (len)
                frame.push_back(8'($urandom_range(0, 255)));
            add_crlf();
        end
    endfunction

    // ---------------- tests ----------------

    task automatic test_stray_bytes();
        frame = '{8'h00, 8'hFF, "a"};
        add_line("*0");
        add_line("*-0");
        send_frame();
    endtask

    task automatic test_count_lines();
        add_line("*-1");
        add_line("*");
        add_line("*x5");
        add_line("*2147483648");
        add_line("*2147483647");
        add_line("$0");
        add_crlf();
        add_text("#");
        send_frame();
    endtask

    task automatic test_length_lines();
        add_line("*1");
        add_line("$-2");
        add_line("*1");
        add_line("$");
        add_line("*1");
        add_text("$1");
        frame.push_back(CH_CR);
        add_line("z");
        add_line("Q");
        send_frame();
    endtask

    task automatic test_payload_terminator();
        add_line("*2");
        add_line("$1");
        add_text("A");
        frame.push_back(CH_LF);
        add_line("*1");
        add_line("$1");
        add_text("B");
        frame.push_back(CH_CR);
        add_text("*");
        add_line("*1");
        add_line("$0");
        add_crlf();
        send_frame();
    endtask

    task automatic test_drain_pause();
        add_command(2, 5);
        send_frame();
        wait_drained();
        add_command(1, 3);
        send_frame();
        wait_drained();
    endtask

    task automatic test_steady_stream();
        int stop_at;
        stop_at   = bytes_sent + 200;
        send_idle = 1'b0;
        recv_idle = 1'b0;
        while (bytes_sent < stop_at)
        begin
            add_command($urandom_range(0, 4), 8);
            send_frame();
        end
        send_idle = 1'b1;
        recv_idle = 1'b1;
    endtask

    task automatic test_random_requests();
        int stop_at;
        int pick;
        stop_at = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 75)
                add_command($urandom_range(0, 4), 8);
            else if (pick < 88)
            begin
                add_command($urandom_range(1, 3), 6);
                frame[$urandom_range(0, frame.size() - 1)] = 8'($urandom_range(0, 255));
            end
            else if (pick < 94)
            begin
                if ($urandom_range(1))
                    add_bad_number_line(CH_STAR);
                else
                begin
                    add_number_line(CH_STAR, $urandom_range(1, 3));
                    add_bad_number_line(CH_DOLLAR);
                end
            end
            else
                repeat ($urandom_range(1, 4))
                    frame.push_back(8'($urandom_range(0, 255)));
            send_frame();
            if ($urandom_range(99) == 0)
                wait_drained();
        end
    endtask

    initial
    begin
        reset_parser();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_stray_bytes();
        test_count_lines();
        test_length_lines();
        test_payload_terminator();
        test_drain_pause();
        test_steady_stream();
        test_random_requests();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("resp_multibulk_command_parser_test: clean");
        else
            $display("resp_multibulk_command_parser_test: errors");
        $finish;
    end

endmodule

### sim.f
+incdir+src
src/rmbp_pkg.sv
src/rmbp_front.sv
src/rmbp_queue.sv
src/rmbp_back.sv
src/resp_multibulk_command_parser.sv
src/rmbp_checker.sv
bench/resp_multibulk_command_parser_test.sv
